[src/sha2_hash_engine_defines.svh]
// Assertion shorthands for the hash engine. Both expect clk and rst_n in scope.
`ifndef SHA2_HASH_ENGINE_DEFINES_SVH
`define SHA2_HASH_ENGINE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHA2_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SHA2_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/sha2_pkg.sv]
`default_nettype none

package sha2_pkg;

    localparam int WORD_W       = 32;
    localparam int VB_W         = 3;
    localparam int BLOCK_WORDS  = 16;
    localparam int DIGEST_WORDS = 8;
    localparam int TRUNC_WORDS  = 7;
    localparam int IDX_W        = 3;
    localparam int ROUND_W      = 6;
    localparam int ROUNDS       = 64;
    localparam int LEN_W        = 64;
    // The message length is kept in bytes; the bit length is this count times eight.
    localparam int COUNT_W      = LEN_W - 3;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic               capture;
        logic               ins_msg;
        logic               ins_pad;
        logic               ins_zero;
        logic               ins_len;
        logic               load_vars;
        logic               round;
        logic [ROUND_W-1:0] round_idx;
        logic               fold;
        logic               out_load;
        logic [IDX_W-1:0]   out_idx;
        logic               out_last;
        logic               reinit;
    } sha2_cmd_t;

    typedef struct packed {
        logic truncated;
    } sha2_status_t;

    localparam word_t ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam word_t IV_FULL [DIGEST_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t IV_TRUNC [DIGEST_WORDS] = '{
        32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
        32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
    };

endpackage

`default_nettype wire

[src/sha2_msg_if.sv]
`default_nettype none

interface sha2_msg_if import sha2_pkg::*; ();
    logic            valid;
    logic            ready;
    word_t           msg_word;
    logic [VB_W-1:0] valid_bytes;
    logic            last_word;

    modport source (output valid, output msg_word, output valid_bytes, output last_word,
                    input ready);
    modport sink (input valid, input msg_word, input valid_bytes, input last_word,
                  output ready);
endinterface

`default_nettype wire

[src/sha2_dig_if.sv]
`default_nettype none

interface sha2_dig_if import sha2_pkg::*; ();
    logic  valid;
    logic  ready;
    word_t digest_word;
    logic  digest_last;
    logic  too_long;

    modport source (output valid, output digest_word, output digest_last, output too_long,
                    input ready);
    modport sink (input valid, input digest_word, input digest_last, input too_long,
                  output ready);
endinterface

`default_nettype wire

[src/sha2_datapath.sv]
`default_nettype none

module sha2_datapath import sha2_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_data,
    input  word_t        msg_word,
    input  sha2_cmd_t    cmd,
    output sha2_status_t status,
    output word_t        digest_word,
    output logic         digest_last,
    output logic         too_long
);

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    logic               truncated_reg;
    word_t              chain_reg [DIGEST_WORDS];
    word_t              chain_next [DIGEST_WORDS];
    word_t              w_reg [BLOCK_WORDS];
    word_t              w_next [BLOCK_WORDS];
    word_t              v_reg [DIGEST_WORDS];
    word_t              v_next [DIGEST_WORDS];
    word_t              hold_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               ovf_reg;
    word_t              digest_word_reg;
    logic               digest_last_reg;
    logic               too_long_reg;

    logic [7:0]         ins_byte;
    logic               ins_any;
    logic [COUNT_W:0]   count_sum;
    logic               iv_sel;
    word_t              sched_new;
    word_t              t1;
    word_t              t2;

    assign ins_byte  = cmd.ins_msg ? hold_reg[WORD_W-1 -: 8] : (cmd.ins_pad ? 8'h80 : 8'h00);
    assign ins_any   = cmd.ins_msg || cmd.ins_pad || cmd.ins_zero;
    assign count_sum = {1'b0, count_reg} + (COUNT_W + 1)'(1);
    assign iv_sel    = cfg_we ? cfg_data : truncated_reg;

    assign sched_new = (rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10))
                     + w_reg[9]
                     + (rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3))
                     + w_reg[0];

    // v_reg holds a through h in order.
    assign t1 = v_reg[7]
              + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + ROUND_K[cmd.round_idx]
              + w_reg[0];
    assign t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    // The block window is one big shift register: bytes enter at the bottom while
    // the block fills, and words leave at the top while the schedule runs.
    always_comb
    begin
        for (int i = 0; i < BLOCK_WORDS; i++)
        begin
            w_next[i] = w_reg[i];
        end
        if (ins_any)
        begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++)
            begin
                w_next[i] = {w_reg[i][WORD_W-9:0], w_reg[i+1][WORD_W-1 -: 8]};
            end
            w_next[BLOCK_WORDS-1] = {w_reg[BLOCK_WORDS-1][WORD_W-9:0], ins_byte};
        end
        else if (cmd.ins_len)
        begin
            for (int i = 0; i < BLOCK_WORDS - 2; i++)
            begin
                w_next[i] = w_reg[i+2];
            end
            w_next[BLOCK_WORDS-2] = count_reg[COUNT_W-1 -: WORD_W];
            w_next[BLOCK_WORDS-1] = {count_reg[LEN_W-WORD_W-4:0], 3'b000};
        end
        else if (cmd.round)
        begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++)
            begin
                w_next[i] = w_reg[i+1];
            end
            w_next[BLOCK_WORDS-1] = sched_new;
        end
    end

    always_comb
    begin
        for (int i = 0; i < DIGEST_WORDS; i++)
        begin
            v_next[i]     = v_reg[i];
            chain_next[i] = chain_reg[i];
        end
        if (cmd.load_vars)
        begin
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                v_next[i] = chain_reg[i];
            end
        end
        else if (cmd.round)
        begin
            for (int i = 1; i < DIGEST_WORDS; i++)
            begin
                v_next[i] = v_reg[i-1];
            end
            v_next[4] = v_reg[3] + t1;
            v_next[0] = t1 + t2;
        end
        if (cfg_we || cmd.reinit)
        begin
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                chain_next[i] = iv_sel ? IV_TRUNC[i] : IV_FULL[i];
            end
        end
        else if (cmd.fold)
        begin
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                chain_next[i] = chain_reg[i] + v_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            truncated_reg <= 1'b0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                chain_reg[i] <= IV_FULL[i];
            end
        end
        else
        begin
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                chain_reg[i] <= chain_next[i];
            end
            if (cfg_we)
            begin
                truncated_reg <= cfg_data;
            end
            if (cfg_we || cmd.reinit)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else if (cmd.ins_msg)
            begin
                count_reg <= count_sum[COUNT_W-1:0];
                ovf_reg   <= ovf_reg | count_sum[COUNT_W];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < BLOCK_WORDS; i++)
        begin
            w_reg[i] <= w_next[i];
        end
        for (int i = 0; i < DIGEST_WORDS; i++)
        begin
            v_reg[i] <= v_next[i];
        end
        if (cmd.capture)
        begin
            hold_reg <= msg_word;
        end
        else if (cmd.ins_msg)
        begin
            hold_reg <= {hold_reg[WORD_W-9:0], 8'h00};
        end
        if (cmd.out_load)
        begin
            digest_word_reg <= chain_reg[cmd.out_idx];
            digest_last_reg <= cmd.out_last;
            too_long_reg    <= ovf_reg;
        end
    end

    assign status.truncated = truncated_reg;
    assign digest_word      = digest_word_reg;
    assign digest_last      = digest_last_reg;
    assign too_long         = too_long_reg;

endmodule

`default_nettype wire

[src/sha2_controller.sv]
`default_nettype none

`include "sha2_hash_engine_defines.svh"

module sha2_controller import sha2_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [VB_W-1:0] valid_bytes,
    input  logic            last_word,
    output logic            out_valid,
    input  logic            out_ready,
    input  sha2_status_t    status,
    output sha2_cmd_t       cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_BYTE  = 4'd1;
    localparam logic [3:0] S_PAD80 = 4'd2;
    localparam logic [3:0] S_PADZ  = 4'd3;
    localparam logic [3:0] S_LEN   = 4'd4;
    localparam logic [3:0] S_LOADV = 4'd5;
    localparam logic [3:0] S_ROUND = 4'd6;
    localparam logic [3:0] S_FOLD  = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    localparam logic [1:0] PH_MSG   = 2'd0;
    localparam logic [1:0] PH_SPILL = 2'd1;
    localparam logic [1:0] PH_FINAL = 2'd2;

    localparam logic [5:0]         FILL_LAST  = 6'd63;
    localparam logic [5:0]         FILL_LEN   = 6'd56;
    localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(ROUNDS - 1);

    logic [3:0]         state_reg, state_next;
    logic [5:0]         fill_reg, fill_next;
    logic [2:0]         left_reg, left_next;
    logic               last_reg, last_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic [1:0]         phase_reg, phase_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;

    logic               accept;
    logic [2:0]         nbytes;
    logic [IDX_W-1:0]   last_idx;
    logic               fill_full;
    logic               fill_len;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign nbytes    = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
    assign last_idx  = status.truncated ? IDX_W'(TRUNC_WORDS - 1) : IDX_W'(DIGEST_WORDS - 1);
    assign fill_full = (fill_reg == FILL_LAST);
    assign fill_len  = (fill_reg == FILL_LEN - 6'd1);

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        left_next      = left_reg;
        last_next      = last_reg;
        round_next     = round_reg;
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.round_idx  = round_reg;
        cmd.out_idx    = idx_reg;
        cmd.out_last   = (idx_reg == last_idx);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    left_next   = nbytes;
                    last_next   = last_word;
                    if (nbytes != 3'd0)
                    begin
                        state_next = S_BYTE;
                    end
                    else if (last_word)
                    begin
                        state_next = S_PAD80;
                    end
                end
            end
            S_BYTE:
            begin
                cmd.ins_msg = 1'b1;
                fill_next   = fill_reg + 6'd1;
                left_next   = left_reg - 3'd1;
                if (fill_full)
                begin
                    phase_next = PH_MSG;
                    state_next = S_LOADV;
                end
                else if (left_reg == 3'd1)
                begin
                    state_next = last_reg ? S_PAD80 : S_IDLE;
                end
            end
            S_PAD80, S_PADZ:
            begin
                cmd.ins_pad  = (state_reg == S_PAD80);
                cmd.ins_zero = (state_reg == S_PADZ);
                fill_next    = fill_reg + 6'd1;
                // A full block here means the length has to go into one more block.
                if (fill_full)
                begin
                    phase_next = PH_SPILL;
                    state_next = S_LOADV;
                end
                else if (fill_len)
                begin
                    state_next = S_LEN;
                end
                else
                begin
                    state_next = S_PADZ;
                end
            end
            S_LEN:
            begin
                cmd.ins_len = 1'b1;
                phase_next  = PH_FINAL;
                state_next  = S_LOADV;
            end
            S_LOADV:
            begin
                cmd.load_vars = 1'b1;
                state_next    = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round  = 1'b1;
                round_next = round_reg + ROUND_W'(1);
                if (round_reg == ROUND_LAST)
                begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                cmd.fold = 1'b1;
                unique case (phase_reg)
                    PH_MSG:
                    begin
                        if (left_reg != 3'd0)
                        begin
                            state_next = S_BYTE;
                        end
                        else
                        begin
                            state_next = last_reg ? S_PAD80 : S_IDLE;
                        end
                    end
                    PH_SPILL: state_next = S_PADZ;
                    PH_FINAL: state_next = S_EMIT;
                    default:  state_next = S_IDLE;
                endcase
            end
            S_EMIT:
            begin
                cmd.out_load   = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (idx_reg == last_idx)
                    begin
                        cmd.reinit = 1'b1;
                        idx_next   = '0;
                        fill_next  = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_EMIT;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A variant write restarts the engine and drops whatever was in flight.
        if (cfg_we)
        begin
            state_next     = S_IDLE;
            fill_next      = '0;
            round_next     = '0;
            idx_next       = '0;
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            left_reg      <= '0;
            last_reg      <= 1'b0;
            round_reg     <= '0;
            phase_reg     <= PH_MSG;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            left_reg      <= left_next;
            last_reg      <= last_next;
            round_reg     <= round_next;
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `SHA2_ASSERT_IMP(a_len_at_fill, state_reg == S_LEN, fill_reg == FILL_LEN, "length not at byte 56")
    `SHA2_ASSERT_NXT(a_rounds_end, state_reg == S_ROUND && round_reg == ROUND_LAST && !cfg_we, state_reg == S_FOLD, "round 63 not followed by fold")
    `SHA2_ASSERT_IMP(a_ready_excl, in_ready, !out_valid_reg, "input taken while a digest word waits")
    `SHA2_ASSERT_IMP(a_valid_state, out_valid_reg, state_reg == S_OUT, "digest valid outside output state")

endmodule

`default_nettype wire

[src/sha2_hash_engine.sv]
// An accepted word is captured, then its valid bytes are inserted byte by byte; each
// filled 64-byte block is compressed (load, 64 rounds, feed-forward add) by the
// single-round compressor. Final word: padding one byte per cycle up to byte 56, the
// length, then compression (a second padded block on a spill); each digest word (7 or 8
// words) is loaded and held until taken. New words are accepted only in the idle state.
// Reset: SHA-256 initial values, variant 0, counts and overflow flag cleared, no output.
`default_nettype none

module sha2_hash_engine import sha2_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    sha2_msg_if.sink          msg,
    sha2_dig_if.source        dig,
    input  logic              cfg_we,
    input  logic              cfg_data
);

    sha2_cmd_t    cmd;
    sha2_status_t status;

    sha2_controller u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .in_valid    (msg.valid),
        .in_ready    (msg.ready),
        .valid_bytes (msg.valid_bytes),
        .last_word   (msg.last_word),
        .out_valid   (dig.valid),
        .out_ready   (dig.ready),
        .status      (status),
        .cmd         (cmd)
    );

    sha2_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .msg_word    (msg.msg_word),
        .cmd         (cmd),
        .status      (status),
        .digest_word (dig.digest_word),
        .digest_last (dig.digest_last),
        .too_long    (dig.too_long)
    );

endmodule

`default_nettype wire
